[hdl/epcb_pkg.sv]
// ----------------------------------------------------------------------------
// epcb_pkg
// Types, constants and helpers shared by the expiring pwm command bank.
// ----------------------------------------------------------------------------
package epcb_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_MAX       = 8;
    localparam int MASK_W         = 8;
    localparam int PWM_W          = 8;
    localparam int TIME_W         = 32;
    localparam int WORD_W         = PWM_W + TIME_W + TIME_W;

    typedef logic [MASK_W-1:0]        mask_t;
    typedef logic signed [PWM_W-1:0]  pwm_t;
    typedef logic [TIME_W-1:0]        time_t;

    localparam pwm_t PWM_LIMIT_POS = pwm_t'(100);
    localparam pwm_t PWM_LIMIT_NEG = pwm_t'(-100);

    typedef enum logic [1:0] {
        OP_SET,
        OP_READ,
        OP_REFRESH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [3:0] slot;
        pwm_t       pwm_value;
        time_t      hold_time;
        time_t      now_ms;
    } cmd_t;

    typedef struct packed {
        pwm_t  read_value;
        mask_t active_mask;
    } rsp_t;

    typedef struct packed {
        pwm_t  value;
        time_t stamp;
        time_t hold;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_DATA,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic pwm_t clamp_pwm(input pwm_t value);
        pwm_t result;
        if (value > PWM_LIMIT_POS)
        begin
            result = PWM_LIMIT_POS;
        end
        else if (value < PWM_LIMIT_NEG)
        begin
            result = PWM_LIMIT_NEG;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

[hdl/epcb_ram.sv]
// ----------------------------------------------------------------------------
// epcb_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module epcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/expiring_pwm_command_bank_top.sv]
// ----------------------------------------------------------------------------
// expiring_pwm_command_bank_top
// Bank of pwm command slots with per-slot hold time and expiry refresh.
//
// Command channel (cmd_valid, cmd_stall, cmd): one request is taken when
// cmd_valid is high and cmd_stall low. cmd_stall is high while a request
// is in work. Set stores the clamped value, stamp and hold time of a slot;
// read returns the slot value if active; refresh expires every active slot
// whose elapsed time is strictly above its hold time.
// Response channel (rsp_valid, rsp_stall, rsp): one response per request,
// held in an output register while rsp_stall is high.
// Slot entries live in one ram with registered read data; the active
// bits are flip-flops. A request runs to its response before the next one
// is taken: cmd_stall stays high until the response is loaded. Refresh
// walks the slots through the single read port with one comparator; an
// out-of-range slot or unused code goes straight to the final state.
// While the response register is full and stalled, a finished request waits
// in its final state. Reset clears all active bits and the response valid.
// ----------------------------------------------------------------------------
module expiring_pwm_command_bank_top #(
    parameter int SLOT_COUNT = epcb_pkg::SLOT_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  epcb_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output epcb_pkg::rsp_t  rsp
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    epcb_pkg::state_t state_reg, state_next;
    epcb_pkg::cmd_t   cmd_reg, cmd_next;
    epcb_pkg::pwm_t   result_reg, result_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    epcb_pkg::rsp_t    rsp_reg, rsp_next;

    logic              accept;
    logic [SLOT_W-1:0] slot_idx;
    logic              out_free;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic              load_rsp;
    epcb_pkg::entry_t  wr_entry;
    epcb_pkg::entry_t  rd_entry;
    epcb_pkg::time_t   elapsed;

    assign accept   = cmd_valid && !cmd_stall;
    assign slot_idx = cmd_reg.slot[SLOT_W-1:0];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign elapsed  = cmd_reg.now_ms - rd_entry.stamp;

    assign wr_entry.value = epcb_pkg::clamp_pwm(cmd_reg.pwm_value);
    assign wr_entry.stamp = cmd_reg.now_ms;
    assign wr_entry.hold  = cmd_reg.hold_time;

    epcb_ram #(
        .WIDTH (epcb_pkg::WORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_idx),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            epcb_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.operation)
                        epcb_pkg::OP_SET:
                        begin
                            state_next = (int'(cmd.slot) < SLOT_COUNT) ?
                                         epcb_pkg::ST_WRITE : epcb_pkg::ST_DONE;
                        end
                        epcb_pkg::OP_READ:
                        begin
                            state_next = (int'(cmd.slot) < SLOT_COUNT) ?
                                         epcb_pkg::ST_READ : epcb_pkg::ST_DONE;
                        end
                        epcb_pkg::OP_REFRESH:
                        begin
                            state_next = epcb_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = epcb_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            epcb_pkg::ST_WRITE:     state_next = epcb_pkg::ST_DONE;
            epcb_pkg::ST_READ:      state_next = epcb_pkg::ST_READ_DATA;
            epcb_pkg::ST_READ_DATA: state_next = epcb_pkg::ST_DONE;
            epcb_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = epcb_pkg::ST_DRAIN;
                end
            end
            epcb_pkg::ST_DRAIN:     state_next = epcb_pkg::ST_DONE;
            epcb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = epcb_pkg::ST_IDLE;
                end
            end
            default:                state_next = epcb_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_stall   = 1'b1;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = slot_idx;
        load_rsp    = 1'b0;
        case (state_reg)
            epcb_pkg::ST_IDLE:  cmd_stall = 1'b0;
            epcb_pkg::ST_WRITE: ram_wr_en = 1'b1;
            epcb_pkg::ST_READ:  ram_rd_en = 1'b1;
            epcb_pkg::ST_SCAN:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg;
            end
            epcb_pkg::ST_DONE:  load_rsp = out_free;
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cmd_next       = cmd_reg;
        result_next    = result_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        chk_vld_next   = (state_reg == epcb_pkg::ST_SCAN);
        chk_idx_next   = idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (accept)
        begin
            cmd_next    = cmd;
            result_next = '0;
            idx_next    = '0;
        end

        if (state_reg == epcb_pkg::ST_SCAN)
        begin
            idx_next = idx_reg + SLOT_W'(1);
        end

        if (state_reg == epcb_pkg::ST_WRITE)
        begin
            active_next[slot_idx] = 1'b1;
        end

        if (state_reg == epcb_pkg::ST_READ_DATA && active_reg[slot_idx])
        begin
            result_next = rd_entry.value;
        end

        // expiry check on the entry read in the previous cycle
        if (chk_vld_reg && active_reg[chk_idx_reg] && (elapsed > rd_entry.hold))
        begin
            active_next[chk_idx_reg] = 1'b0;
        end

        if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.read_value  = result_reg;
            rsp_next.active_mask = epcb_pkg::mask_t'(active_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= epcb_pkg::ST_IDLE;
            active_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        result_reg  <= result_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != epcb_pkg::ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_active_rise_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != epcb_pkg::ST_WRITE |=> (active_reg & ~$past(active_reg)) == '0)
        else $error("active bit set outside a set write");

    a_check_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == epcb_pkg::ST_SCAN || state_reg == epcb_pkg::ST_DRAIN))
        else $error("expiry check outside a refresh");

    a_rsp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.read_value <= epcb_pkg::PWM_LIMIT_POS &&
                       rsp.read_value >= epcb_pkg::PWM_LIMIT_NEG))
        else $error("read value outside the clamp range");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the expiring pwm command bank against its own slot tracker. The
// tracker keeps the values, stamps, hold times and active bits. For each
// accepted request it works out the response and compares it, field by
// field, with the response that the block returns. Directed requests cover
// clamping, out-of-range slots, the unused code, wrapping time and the
// expiry boundary. Random requests follow under four idling regimes.
// ----------------------------------------------------------------------------
class slot_bank_tracker;
    int                       slot_total;
    epcb_pkg::pwm_t           slot_value[epcb_pkg::SLOT_MAX];
    epcb_pkg::time_t          slot_stamp[epcb_pkg::SLOT_MAX];
    epcb_pkg::time_t          slot_hold[epcb_pkg::SLOT_MAX];
    epcb_pkg::mask_t          live_mask;
    epcb_pkg::rsp_t           expected_rsp[$];
    int                       error_count;

    function new(int slots);
        slot_total  = slots;
        live_mask   = '0;
        error_count = 0;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function void take_request(epcb_pkg::cmd_t c);
        epcb_pkg::rsp_t  r;
        int              idx;
        int              level;
        epcb_pkg::time_t elapsed;
        r.read_value = '0;
        idx = int'(c.slot);
        case (c.operation)
            epcb_pkg::OP_SET:
            begin
                if (idx < slot_total)
                begin
                    level = int'(c.pwm_value);
                    if (level > 100)
                    begin
                        level = 100;
                    end
                    else if (level < -100)
                    begin
                        level = -100;
                    end
                    slot_value[idx] = epcb_pkg::pwm_t'(level);
                    slot_stamp[idx] = c.now_ms;
                    slot_hold[idx]  = c.hold_time;
                    live_mask[idx]  = 1'b1;
                end
            end
            epcb_pkg::OP_READ:
            begin
                if (idx < slot_total)
                begin
                    if (live_mask[idx])
                    begin
                        r.read_value = slot_value[idx];
                    end
                    else
                    begin
                        slot_value[idx] = '0;
                    end
                end
            end
            epcb_pkg::OP_REFRESH:
            begin
                for (int i = 0; i < slot_total; i++)
                begin
                    if (live_mask[i])
                    begin
                        elapsed = c.now_ms - slot_stamp[i];
                        if (elapsed > slot_hold[i])
                        begin
                            live_mask[i] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.active_mask = live_mask;
        expected_rsp.push_back(r);
    endfunction

    task match_response(epcb_pkg::rsp_t got);
        epcb_pkg::rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            report($sformatf("response %0d/%02h with no request pending",
                             got.read_value, got.active_mask));
            return;
        end
        want = expected_rsp.pop_front();
        if (got.read_value !== want.read_value)
        begin
            report($sformatf("read_value %0d, expected %0d",
                             got.read_value, want.read_value));
        end
        if (got.active_mask !== want.active_mask)
        begin
            report($sformatf("active_mask %02h, expected %02h",
                             got.active_mask, want.active_mask));
        end
    endtask
endclass

module testbench;

    localparam int SLOTS           = epcb_pkg::SLOT_COUNT_DEF;
    localparam int PHASE_REQUESTS  = 231;
    localparam int SETTLE_CYCLES   = 4 * SLOTS + 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic            clk;
    logic            rst_n;
    logic            cmd_valid;
    logic            cmd_stall;
    epcb_pkg::cmd_t  cmd;
    logic            rsp_valid;
    logic            rsp_stall;
    epcb_pkg::rsp_t  rsp;

    int              send_idle_pct;
    int              recv_stall_pct;
    int              quiet_cycles;
    epcb_pkg::time_t ms_base;

    slot_bank_tracker board;

    expiring_pwm_command_bank_top #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic epcb_pkg::cmd_t make_request(epcb_pkg::op_t op, int slot_idx,
                                                    int level, epcb_pkg::time_t hold,
                                                    epcb_pkg::time_t now);
        epcb_pkg::cmd_t c;
        c.operation = op;
        c.slot      = 4'(slot_idx);
        c.pwm_value = epcb_pkg::pwm_t'(level);
        c.hold_time = hold;
        c.now_ms    = now;
        return c;
    endfunction

    function automatic epcb_pkg::cmd_t random_request();
        epcb_pkg::cmd_t c;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            c.operation = epcb_pkg::OP_SET;
        end
        else if (pick < 70)
        begin
            c.operation = epcb_pkg::OP_READ;
        end
        else if (pick < 95)
        begin
            c.operation = epcb_pkg::OP_REFRESH;
        end
        else
        begin
            c.operation = epcb_pkg::OP_NONE;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            c.slot = 4'($urandom_range(SLOTS, 15));
        end
        else
        begin
            c.slot = 4'($urandom_range(0, SLOTS - 1));
        end
        c.pwm_value = epcb_pkg::pwm_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            c.hold_time = epcb_pkg::time_t'($urandom_range(0, 40));
        end
        else if (pick < 80)
        begin
            c.hold_time = '0;
        end
        else if (pick < 85)
        begin
            c.hold_time = '1;
        end
        else
        begin
            c.hold_time = $urandom;
        end
        ms_base = ms_base + epcb_pkg::time_t'($urandom_range(0, 12));
        if ($urandom_range(0, 19) == 0)
        begin
            c.now_ms = $urandom;
        end
        else
        begin
            c.now_ms = ms_base;
        end
        return c;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input epcb_pkg::cmd_t c);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
        board.take_request(c);
        @(negedge clk);
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            board.match_response(rsp);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        board          = new(SLOTS);
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ms_base        = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // clamping, out-of-range slots, unused code, wrapping stamps
        send_request(make_request(epcb_pkg::OP_SET, 0, 127, 10, 1000));
        send_request(make_request(epcb_pkg::OP_SET, 1, -128, 0, 1000));
        send_request(make_request(epcb_pkg::OP_SET, 2, 100, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
        send_request(make_request(epcb_pkg::OP_SET, 3, -100, 5, 32'hFFFF_FFFE));
        send_request(make_request(epcb_pkg::OP_SET, SLOTS - 1, -1, 20, 1000));
        send_request(make_request(epcb_pkg::OP_SET, 8, 50, 7, 1000));
        send_request(make_request(epcb_pkg::OP_SET, 15, -7, 7, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 0, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 1, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 2, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 3, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, SLOTS - 1, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 5, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_READ, 15, 0, 0, 1000));
        send_request(make_request(epcb_pkg::OP_NONE, 0, 0, 0, 1000));
        // elapsed equal to hold keeps the slot, one more expires it
        send_request(make_request(epcb_pkg::OP_REFRESH, 0, 0, 0, 1010));
        send_request(make_request(epcb_pkg::OP_REFRESH, 0, 0, 0, 1011));
        send_request(make_request(epcb_pkg::OP_READ, 0, 0, 0, 1011));
        send_request(make_request(epcb_pkg::OP_READ, 1, 0, 0, 1011));
        // time running behind the stamp wraps to a huge elapsed time
        send_request(make_request(epcb_pkg::OP_SET, 4, 1, 3, 3));
        send_request(make_request(epcb_pkg::OP_REFRESH, 0, 0, 0, 2));
        send_request(make_request(epcb_pkg::OP_READ, 4, 0, 0, 2));
        send_request(make_request(epcb_pkg::OP_SET, 6, 0, 0, 1011));
        send_request(make_request(epcb_pkg::OP_REFRESH, 0, 0, 0, 1011));
        send_request(make_request(epcb_pkg::OP_READ, 6, 0, 0, 1011));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    ms_base        = $urandom;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                    ms_base        = 32'hFFFF_FF00;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                    ms_base        = $urandom;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                    ms_base        = $urandom;
                end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                send_request(random_request());
            end
        end
        cmd_valid <= 1'b0;

        while (board.expected_rsp.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
hdl/epcb_pkg.sv
hdl/epcb_ram.sv
hdl/expiring_pwm_command_bank_top.sv
tb/sv/testbench.sv
